FILE: rtl/core/rasr_pkg.sv
// shared types and constants for the rational add/sub/reduce block
// no dependencies; used by every module under rtl/core except rasr_div
package rasr_pkg;

  localparam int unsigned FieldW = 32;

  typedef enum logic [1:0] {
    CMD_REDUCE = 2'd0,
    CMD_ADD    = 2'd1,
    CMD_SUB    = 2'd2,
    CMD_EQUAL  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_ZERO_DEN = 2'd1,
    ST_RANGE    = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    PH_A = 2'd0,
    PH_B = 2'd1,
    PH_R = 2'd2
  } phase_e;

  typedef enum logic [3:0] {
    BK_IDLE,
    BK_GCD,
    BK_DIVN,
    BK_DIVN_W,
    BK_DIVD,
    BK_DIVD_W,
    BK_FIX,
    BK_MULP,
    BK_MULQ,
    BK_MULD,
    BK_ADD,
    BK_CHECK,
    BK_DONE
  } back_state_e;

  typedef struct packed {
    logic [1:0]               cmd;
    logic signed [FieldW-1:0] a_num;
    logic signed [FieldW-1:0] a_den;
    logic signed [FieldW-1:0] b_num;
    logic signed [FieldW-1:0] b_den;
  } in_t;

  typedef struct packed {
    logic signed [FieldW-1:0] res_num;
    logic [FieldW-2:0]        res_den;
    logic                     is_equal;
    logic [1:0]               status;
  } out_t;

  // classified item between front and back: magnitudes at full field width
  typedef struct packed {
    logic [1:0]        cmd;
    logic              zero_err;
    logic              a_neg;
    logic [FieldW-1:0] a_mag;
    logic [FieldW-1:0] a_den;
    logic              b_neg;
    logic [FieldW-1:0] b_mag;
    logic [FieldW-1:0] b_den;
  } entry_t;

endpackage

FILE: rtl/core/rasr_front.sv
// front end: splits operands into sign and magnitude, flags zero denominators
// depends on rasr_pkg
module rasr_front #(
  parameter int unsigned OPERAND_WIDTH = 32
) (
  input  rasr_pkg::in_t    item_i,
  output rasr_pkg::entry_t entry_o
);

  localparam int unsigned W = OPERAND_WIDTH;

  logic [W-1:0] an, ad, bn, bd;
  logic [W-1:0] an_m, ad_m, bn_m, bd_m;
  logic         za, zb;

  assign an = item_i.a_num[W-1:0];
  assign ad = item_i.a_den[W-1:0];
  assign bn = item_i.b_num[W-1:0];
  assign bd = item_i.b_den[W-1:0];

  // most negative value maps onto its own magnitude, 2^(w-1)
  assign an_m = an[W-1] ? W'(-an) : an;
  assign ad_m = ad[W-1] ? W'(-ad) : ad;
  assign bn_m = bn[W-1] ? W'(-bn) : bn;
  assign bd_m = bd[W-1] ? W'(-bd) : bd;

  assign za = (ad_m == '0);
  assign zb = (bd_m == '0);

  always_comb begin
    entry_o          = '0;
    entry_o.cmd      = item_i.cmd;
    entry_o.zero_err = za || ((item_i.cmd != rasr_pkg::CMD_REDUCE) && zb);
    entry_o.a_neg    = an[W-1] ^ ad[W-1];
    entry_o.a_mag    = rasr_pkg::FieldW'(an_m);
    entry_o.a_den    = za ? rasr_pkg::FieldW'(1) : rasr_pkg::FieldW'(ad_m);
    entry_o.b_neg    = bn[W-1] ^ bd[W-1];
    entry_o.b_mag    = rasr_pkg::FieldW'(bn_m);
    entry_o.b_den    = zb ? rasr_pkg::FieldW'(1) : rasr_pkg::FieldW'(bd_m);
  end

endmodule

FILE: rtl/core/rasr_queue.sv
// short register queue of classified items between front and back
// depends on rasr_pkg
module rasr_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  rasr_pkg::entry_t data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             empty_o,
  output rasr_pkg::entry_t data_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  rasr_pkg::entry_t  mem_q [DEPTH];
  logic [PW-1:0]     wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0]     cnt_q, cnt_d;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop_i) begin
      rd_d = (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

FILE: rtl/core/rasr_div.sv
// restoring divider, one quotient bit per cycle
// no package dependency
module rasr_div #(
  parameter int unsigned DW = 64
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [DW-1:0] dividend_i,
  input  logic [DW-1:0] divisor_i,
  output logic          done_o,
  output logic [DW-1:0] quo_o
);

  localparam int unsigned CW = $clog2(DW + 1);

  logic          busy_q, done_q;
  logic [CW-1:0] cnt_q;
  logic [DW-1:0] rem_q, quo_q, dvs_q;
  logic [DW:0]   rem_sh, diff;

  assign rem_sh = {rem_q, quo_q[DW-1]};
  assign diff   = rem_sh - {1'b0, dvs_q};
  assign done_o = done_q;
  assign quo_o  = quo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(DW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      if (!diff[DW]) begin
        rem_q <= diff[DW-1:0];
        quo_q <= {quo_q[DW-2:0], 1'b1};
      end else begin
        rem_q <= rem_sh[DW-1:0];
        quo_q <= {quo_q[DW-2:0], 1'b0};
      end
    end
  end

endmodule

FILE: rtl/core/rasr_back.sv
// back end: sequencer with binary gcd, shared divider and one multiplier
// depends on rasr_pkg and rasr_div
module rasr_back #(
  parameter int unsigned OPERAND_WIDTH = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             empty_i,
  input  rasr_pkg::entry_t entry_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output rasr_pkg::out_t   out_data_o
);

  localparam int unsigned W  = OPERAND_WIDTH;
  localparam int unsigned DW = 2 * OPERAND_WIDTH;
  localparam int unsigned KW = $clog2(DW + 1);
  localparam logic [DW-1:0] Lim = DW'(1) << (W - 1);

  rasr_pkg::back_state_e state_q, state_d;
  rasr_pkg::entry_t      cur_q;
  rasr_pkg::phase_e      ph_q;
  rasr_pkg::out_t        res_q, out_q;
  logic                  out_valid_q;

  logic [DW-1:0] wn_q, wd_q, gu_q, gv_q, g_q, p_q, qv_q;
  logic [KW-1:0] gk_q;
  logic          rneg_q;
  logic [W-1:0]  ra_n_q, ra_d_q, rb_n_q, rb_d_q;
  logic          ra_neg_q, rb_neg_q;

  logic          div_start, div_done;
  logic [DW-1:0] div_n, div_q;
  logic [W-1:0]  mul_x, mul_y;
  logic [DW-1:0] prod;
  logic          out_free;
  logic [DW-1:0] fix_d;
  logic          fix_neg, qneg, ovf;
  logic [W-1:0]  num_w;

  rasr_div #(.DW(DW)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_n),
    .divisor_i  (g_q),
    .done_o     (div_done),
    .quo_o      (div_q)
  );

  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign prod        = DW'(mul_x) * DW'(mul_y);

  assign fix_d = (wn_q == '0) ? DW'(1) : wd_q;
  always_comb begin
    case (ph_q)
      rasr_pkg::PH_A: fix_neg = cur_q.a_neg;
      rasr_pkg::PH_B: fix_neg = cur_q.b_neg;
      default:        fix_neg = rneg_q;
    endcase
    fix_neg = fix_neg && (wn_q != '0);
  end

  assign qneg  = (cur_q.cmd == rasr_pkg::CMD_SUB) ? !rb_neg_q : rb_neg_q;
  assign ovf   = (rneg_q ? (wn_q > Lim) : (wn_q > Lim - 1'b1)) || (wd_q > Lim - 1'b1);
  assign num_w = rneg_q ? W'(-wn_q[W-1:0]) : wn_q[W-1:0];

  // outputs of the sequencer
  always_comb begin
    pop_o     = (state_q == rasr_pkg::BK_IDLE) && !empty_i;
    div_start = (state_q == rasr_pkg::BK_DIVN) || (state_q == rasr_pkg::BK_DIVD);
    div_n     = (state_q == rasr_pkg::BK_DIVN) ? wn_q : wd_q;
    case (state_q)
      rasr_pkg::BK_MULP: begin
        mul_x = ra_n_q;
        mul_y = rb_d_q;
      end
      rasr_pkg::BK_MULQ: begin
        mul_x = rb_n_q;
        mul_y = ra_d_q;
      end
      default: begin
        mul_x = ra_d_q;
        mul_y = rb_d_q;
      end
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      rasr_pkg::BK_IDLE: begin
        if (!empty_i) begin
          state_d = entry_i.zero_err ? rasr_pkg::BK_DONE : rasr_pkg::BK_GCD;
        end
      end
      rasr_pkg::BK_GCD: begin
        if (gu_q == '0 || gv_q == '0) state_d = rasr_pkg::BK_DIVN;
      end
      rasr_pkg::BK_DIVN:   state_d = rasr_pkg::BK_DIVN_W;
      rasr_pkg::BK_DIVN_W: if (div_done) state_d = rasr_pkg::BK_DIVD;
      rasr_pkg::BK_DIVD:   state_d = rasr_pkg::BK_DIVD_W;
      rasr_pkg::BK_DIVD_W: if (div_done) state_d = rasr_pkg::BK_FIX;
      rasr_pkg::BK_FIX: begin
        case (ph_q)
          rasr_pkg::PH_A: begin
            state_d = (cur_q.cmd == rasr_pkg::CMD_REDUCE) ? rasr_pkg::BK_CHECK
                                                          : rasr_pkg::BK_GCD;
          end
          rasr_pkg::PH_B: begin
            state_d = (cur_q.cmd == rasr_pkg::CMD_EQUAL) ? rasr_pkg::BK_DONE
                                                         : rasr_pkg::BK_MULP;
          end
          default: state_d = rasr_pkg::BK_CHECK;
        endcase
      end
      rasr_pkg::BK_MULP:  state_d = rasr_pkg::BK_MULQ;
      rasr_pkg::BK_MULQ:  state_d = rasr_pkg::BK_MULD;
      rasr_pkg::BK_MULD:  state_d = rasr_pkg::BK_ADD;
      rasr_pkg::BK_ADD:   state_d = rasr_pkg::BK_GCD;
      rasr_pkg::BK_CHECK: state_d = rasr_pkg::BK_DONE;
      rasr_pkg::BK_DONE:  if (out_free) state_d = rasr_pkg::BK_IDLE;
      default:            state_d = rasr_pkg::BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rasr_pkg::BK_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == rasr_pkg::BK_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      rasr_pkg::BK_IDLE: begin
        cur_q <= entry_i;
        ph_q  <= rasr_pkg::PH_A;
        wn_q  <= DW'(entry_i.a_mag);
        wd_q  <= DW'(entry_i.a_den);
        gu_q  <= DW'(entry_i.a_mag);
        gv_q  <= DW'(entry_i.a_den);
        gk_q  <= '0;
        res_q <= '{res_num: '0, res_den: '0, is_equal: 1'b0,
                   status: rasr_pkg::ST_ZERO_DEN};
      end
      rasr_pkg::BK_GCD: begin
        if (gu_q == '0) begin
          g_q <= gv_q << gk_q;
        end else if (gv_q == '0) begin
          g_q <= gu_q << gk_q;
        end else if (!gu_q[0] && !gv_q[0]) begin
          gu_q <= gu_q >> 1;
          gv_q <= gv_q >> 1;
          gk_q <= gk_q + 1'b1;
        end else if (!gu_q[0]) begin
          gu_q <= gu_q >> 1;
        end else if (!gv_q[0]) begin
          gv_q <= gv_q >> 1;
        end else if (gu_q >= gv_q) begin
          gu_q <= gu_q - gv_q;
        end else begin
          gv_q <= gv_q - gu_q;
        end
      end
      rasr_pkg::BK_DIVN_W: if (div_done) wn_q <= div_q;
      rasr_pkg::BK_DIVD_W: if (div_done) wd_q <= div_q;
      rasr_pkg::BK_FIX: begin
        case (ph_q)
          rasr_pkg::PH_A: begin
            ra_n_q   <= wn_q[W-1:0];
            ra_d_q   <= fix_d[W-1:0];
            ra_neg_q <= fix_neg;
            rneg_q   <= fix_neg;
            ph_q     <= rasr_pkg::PH_B;
            gu_q     <= DW'(cur_q.b_mag);
            gv_q     <= DW'(cur_q.b_den);
            gk_q     <= '0;
            // reduce keeps a in the working registers for the range check
            if (cur_q.cmd == rasr_pkg::CMD_REDUCE) begin
              wd_q <= fix_d;
            end else begin
              wn_q <= DW'(cur_q.b_mag);
              wd_q <= DW'(cur_q.b_den);
            end
          end
          rasr_pkg::PH_B: begin
            wd_q     <= fix_d;
            rb_n_q   <= wn_q[W-1:0];
            rb_d_q   <= fix_d[W-1:0];
            rb_neg_q <= fix_neg;
            res_q    <= '{res_num: '0, res_den: '0,
                          is_equal: (ra_neg_q == fix_neg) && (DW'(ra_n_q) == wn_q)
                                    && (DW'(ra_d_q) == fix_d),
                          status: rasr_pkg::ST_OK};
          end
          default: begin
            wd_q   <= fix_d;
            rneg_q <= fix_neg;
          end
        endcase
      end
      rasr_pkg::BK_MULP: p_q  <= prod;
      rasr_pkg::BK_MULQ: qv_q <= prod;
      rasr_pkg::BK_MULD: wd_q <= prod;
      rasr_pkg::BK_ADD: begin
        ph_q <= rasr_pkg::PH_R;
        gv_q <= wd_q;
        gk_q <= '0;
        if (ra_neg_q == qneg) begin
          rneg_q <= ra_neg_q;
          wn_q   <= p_q + qv_q;
          gu_q   <= p_q + qv_q;
        end else if (p_q >= qv_q) begin
          rneg_q <= ra_neg_q;
          wn_q   <= p_q - qv_q;
          gu_q   <= p_q - qv_q;
        end else begin
          rneg_q <= qneg;
          wn_q   <= qv_q - p_q;
          gu_q   <= qv_q - p_q;
        end
      end
      rasr_pkg::BK_CHECK: begin
        if (ovf) begin
          res_q <= '{res_num: '0, res_den: '0, is_equal: 1'b0,
                     status: rasr_pkg::ST_RANGE};
        end else begin
          res_q <= '{res_num: rasr_pkg::FieldW'(signed'(num_w)),
                     res_den: (rasr_pkg::FieldW - 1)'(wd_q[W-2:0]),
                     is_equal: 1'b0,
                     status: rasr_pkg::ST_OK};
        end
      end
      rasr_pkg::BK_DONE: if (out_free) out_q <= res_q;
      default: ;
    endcase
  end

endmodule

FILE: rtl/core/rational_add_sub_reduce.sv
// rational reduce/add/subtract/equality on signed fractions, one result per item
// each item takes up to three reductions, each a binary gcd followed by two divides
// (numerator, then denominator) on the shared divider; the back end works on one
// item at a time; reset: asynchronous active low, empties the queue and drops the
// output valid
module rational_add_sub_reduce #(
  parameter int unsigned OPERAND_WIDTH = 32
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  rasr_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output rasr_pkg::out_t out_data_o
);

  // front classifies each item (sign, magnitude, zero denominator) as it is taken
  // the queue lets the front keep taking items while the back end works, until it fills
  rasr_pkg::entry_t front_entry, head_entry;
  logic             q_full, q_empty, q_pop, q_push;

  assign in_stall_o = q_full;
  assign q_push     = in_valid_i && !q_full;

  rasr_front #(.OPERAND_WIDTH(OPERAND_WIDTH)) u_front (
    .item_i  (in_data_i),
    .entry_o (front_entry)
  );

  rasr_queue #(.DEPTH(2)) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (front_entry),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .data_o  (head_entry)
  );

  // back end reduces a, then b (not for reduce), then the cross-multiplied result (add and
  // subtract only), and holds the finished item in its output register
  rasr_back #(.OPERAND_WIDTH(OPERAND_WIDTH)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (q_empty),
    .entry_i     (head_entry),
    .pop_o       (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule
